// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ANP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("anp assertion failed");

// Clocked property that is also checked during reset.
`define ANP_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("anp reset assertion failed");

`endif

// ===== rtl/anp_pkg.sv =====
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types and constants of the ASCII number parser.
// ----------------------------------------------------------------------------
package anp_pkg;

    localparam int MAX_POSITION_DEF = 255;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int STOP_W  = 8;
    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 6;

    typedef enum logic [1:0] {
        SFX_NONE,
        SFX_K,
        SFX_M,
        SFX_P
    } t_suffix;

    typedef struct packed {
        logic                 is_alnum;
        logic [DIGIT_W-1:0]   digit;
        logic                 is_space;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_hex_mark;
        logic                 is_bin_mark;
        t_suffix              sfx;
        logic                 last;
    } t_ch_info;

endpackage

// ===== rtl/anp_front.sv =====
// ----------------------------------------------------------------------------
// anp_front
// Accepts characters, classifies them and tags each beat with its position.
// ----------------------------------------------------------------------------
module anp_front #(
    parameter int MAX_POSITION = anp_pkg::MAX_POSITION_DEF,
    parameter int POS_W        = $clog2(MAX_POSITION + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_last_char,
    input  logic              i_queue_ready,
    output logic              o_push,
    output anp_pkg::t_ch_info o_info,
    output logic [POS_W-1:0]  o_pos
);
    import anp_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UK    = 8'h4B;
    localparam logic [7:0] CH_LK    = 8'h6B;
    localparam logic [7:0] CH_UM    = 8'h4D;
    localparam logic [7:0] CH_LM    = 8'h6D;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] LOWER_OFS = 8'h57;
    localparam logic [7:0] UPPER_OFS = 8'h37;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       digit_full;
    logic             push;

    assign o_ready = i_queue_ready;
    assign push    = i_valid && i_queue_ready;
    assign o_push  = push;
    assign o_pos   = r_pos;

    always_comb begin
        digit_full = 8'd0;
        o_info     = '0;
        priority if (i_char_code >= CH_0 && i_char_code <= CH_9) begin
            digit_full      = i_char_code - CH_0;
            o_info.is_alnum = 1'b1;
        end else if (i_char_code >= CH_LA && i_char_code <= CH_LZ) begin
            digit_full      = i_char_code - LOWER_OFS;
            o_info.is_alnum = 1'b1;
        end else if (i_char_code >= CH_UA && i_char_code <= CH_UZ) begin
            digit_full      = i_char_code - UPPER_OFS;
            o_info.is_alnum = 1'b1;
        end else begin
            digit_full = 8'd0;
        end
        o_info.digit       = digit_full[DIGIT_W-1:0];
        o_info.is_space    = (i_char_code == CH_SPACE) ||
                             (i_char_code >= CH_TAB && i_char_code <= CH_CR);
        o_info.is_minus    = (i_char_code == CH_MINUS);
        o_info.is_zero     = (i_char_code == CH_0);
        o_info.is_hex_mark = (i_char_code == CH_LX) || (i_char_code == CH_UX);
        o_info.is_bin_mark = (i_char_code == CH_LB) || (i_char_code == CH_UB);
        priority if (i_char_code == CH_LK || i_char_code == CH_UK) begin
            o_info.sfx = SFX_K;
        end else if (i_char_code == CH_LM || i_char_code == CH_UM) begin
            o_info.sfx = SFX_M;
        end else if (i_char_code == CH_LP || i_char_code == CH_UP) begin
            o_info.sfx = SFX_P;
        end else begin
            o_info.sfx = SFX_NONE;
        end
        o_info.last = i_last_char;
    end

    always_comb begin
        n_pos = r_pos;
        if (push) begin
            if (i_last_char) begin
                n_pos = '0;
            end else if (r_pos != POS_W'(MAX_POSITION)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/anp_fifo.sv =====
// ----------------------------------------------------------------------------
// anp_fifo
// Small queue with a registered head stage between front and back.
// ----------------------------------------------------------------------------
module anp_fifo #(
    parameter int DEPTH = anp_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import anp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [WIDTH-1:0] r_dout;
    logic             r_dout_valid;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             n_dout_valid;
    logic             load;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = r_dout_valid;
    assign o_data  = r_dout;
    assign load    = (r_count != '0) && (!r_dout_valid || i_pop);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (load) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        n_count = r_count + CW'(i_push) - CW'(load);
        if (load) begin
            n_dout_valid = 1'b1;
        end else if (i_pop) begin
            n_dout_valid = 1'b0;
        end else begin
            n_dout_valid = r_dout_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dout <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_dout_valid <= 1'b0;
        end else begin
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_count      <= n_count;
            r_dout_valid <= n_dout_valid;
        end
    end

endmodule

// ===== rtl/anp_back.sv =====
// ----------------------------------------------------------------------------
// anp_back
// Parse state machine: sign, base prefix, digit accumulation, suffix, result.
// ----------------------------------------------------------------------------
module anp_back #(
    parameter int MAX_POSITION = anp_pkg::MAX_POSITION_DEF,
    parameter int POS_W        = $clog2(MAX_POSITION + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  anp_pkg::t_ch_info            i_info,
    input  logic [POS_W-1:0]             i_pos,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [anp_pkg::VALUE_W-1:0]  o_number_value,
    output logic                         o_overflow_flag,
    output logic [anp_pkg::STOP_W-1:0]   o_stop_position,
    output logic                         o_suffix_used
);
    import anp_pkg::*;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_BIN,
        RX_OCT
    } t_radix;

    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;
    localparam logic [STOP_W-1:0]  STOP_MAX  = '1;

    t_phase               r_phase, n_phase;
    t_radix               r_radix, n_radix;
    logic                 r_neg, n_neg;
    logic [VALUE_W-1:0]   r_acc, n_acc;
    logic                 r_ovf, n_ovf;
    logic                 r_suffix_mode;
    logic                 r_o_valid;
    logic [VALUE_W-1:0]   r_o_value;
    logic                 r_o_flag;
    logic [STOP_W-1:0]    r_o_stop;
    logic                 r_o_used;

    logic                 take;
    logic                 to_digit;
    logic [DIGIT_W-1:0]   base;
    logic                 digit_hit;
    logic [VALUE_W+3:0]   acc_x;
    logic [VALUE_W+3:0]   prod;
    logic [VALUE_W:0]     sum;
    logic                 stop_emit;
    logic                 end_emit;
    logic                 emit;
    logic [VALUE_W-1:0]   signed_v;
    logic [VALUE_W-1:0]   scaled_v;
    logic                 flag_v;
    logic                 sfx_apply;
    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     stop_p;
    logic [31:0]          stop_ext;
    logic [STOP_W-1:0]    stop_v;

    assign o_ready         = !r_o_valid || i_ready;
    assign take            = i_valid && o_ready;
    assign o_valid         = r_o_valid;
    assign o_number_value  = r_o_value;
    assign o_overflow_flag = r_o_flag;
    assign o_stop_position = r_o_stop;
    assign o_suffix_used   = r_o_used;

    always_comb begin
        n_phase  = r_phase;
        n_radix  = r_radix;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        to_digit = 1'b0;

        unique case (r_phase)
            PH_SPACE, PH_SIGN: begin
                priority if (r_phase == PH_SPACE && i_info.is_space) begin
                    n_phase = r_phase;
                end else if (i_info.is_minus) begin
                    n_neg   = ~r_neg;
                    n_phase = PH_SIGN;
                end else if (i_info.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_radix  = RX_DEC;
                    n_phase  = PH_DIGITS;
                    to_digit = 1'b1;
                end
            end
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                priority if (i_info.is_hex_mark) begin
                    n_radix = RX_HEX;
                end else if (i_info.is_bin_mark) begin
                    n_radix = RX_BIN;
                end else begin
                    n_radix  = RX_OCT;
                    to_digit = 1'b1;
                end
            end
            PH_DIGITS: to_digit = 1'b1;
            default:   to_digit = 1'b0;
        endcase

        acc_x = {4'b0, r_acc};
        unique case (n_radix)
            RX_DEC: begin
                base = DIGIT_W'(10);
                prod = (acc_x << 3) + (acc_x << 1);
            end
            RX_HEX: begin
                base = DIGIT_W'(16);
                prod = acc_x << 4;
            end
            RX_BIN: begin
                base = DIGIT_W'(2);
                prod = acc_x << 1;
            end
            default: begin
                base = DIGIT_W'(8);
                prod = acc_x << 3;
            end
        endcase
        sum       = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(i_info.digit);
        digit_hit = to_digit && i_info.is_alnum && (i_info.digit < base);
        if (digit_hit) begin
            n_acc = sum[VALUE_W-1:0];
            n_ovf = r_ovf || (|prod[VALUE_W+3:VALUE_W]) || sum[VALUE_W];
        end

        stop_emit = to_digit && !digit_hit;
        end_emit  = !stop_emit && i_info.last && (r_phase != PH_DONE);
        emit      = stop_emit || end_emit;

        signed_v  = n_neg ? (VALUE_W'(0) - n_acc) : n_acc;
        flag_v    = n_ovf || (n_neg && (n_acc == NEG_LIMIT));
        sfx_apply = stop_emit && r_suffix_mode && (i_info.sfx != SFX_NONE);
        unique case (i_info.sfx)
            SFX_K:   scaled_v = signed_v << 10;
            SFX_M:   scaled_v = signed_v << 20;
            SFX_P:   scaled_v = signed_v << 12;
            default: scaled_v = signed_v;
        endcase
        if (!sfx_apply) begin
            scaled_v = signed_v;
        end

        pos_inc  = (i_pos == POS_W'(MAX_POSITION)) ? i_pos : i_pos + POS_W'(1);
        stop_p   = (end_emit || sfx_apply) ? pos_inc : i_pos;
        stop_ext = 32'(stop_p);
        stop_v   = (stop_ext > 32'(STOP_MAX)) ? STOP_MAX : stop_ext[STOP_W-1:0];

        if (i_info.last) begin
            n_phase = PH_SPACE;
            n_neg   = 1'b0;
            n_radix = RX_DEC;
            n_acc   = '0;
            n_ovf   = 1'b0;
        end else if (emit) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SPACE;
            r_radix       <= RX_DEC;
            r_neg         <= 1'b0;
            r_acc         <= '0;
            r_ovf         <= 1'b0;
            r_suffix_mode <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_suffix_mode <= i_cfg_wdata;
            end
            if (take) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
            end
            if (take && emit) begin
                r_o_valid <= 1'b1;
                r_o_value <= scaled_v;
                r_o_flag  <= flag_v;
                r_o_stop  <= stop_v;
                r_o_used  <= sfx_apply;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/ascii_number_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_number_parser_top
// Character-stream integer parser with base prefixes and size suffixes.
//
//   channel   direction  handshake            payload
//   chars     in         i_valid / o_ready    i_char_code, i_last_char
//   result    out        o_valid / i_ready    o_number_value, o_overflow_flag,
//                                             o_stop_position, o_suffix_used
//   config    in         i_cfg_we             i_cfg_wdata (suffix mode)
//
// One character per cycle sustained while the queue has room; the digit step uses shifts and adds.
// The beat that ends a number passes the queue and the head register before the parser registers its result.
// The classifier and the parser are split by a QUEUE_DEPTH entry queue plus
// a head register; o_ready drops only while that queue is full.
// Synchronous active-low reset clears parse state, queue and suffix mode.
// ----------------------------------------------------------------------------
module ascii_number_parser_top #(
    parameter int MAX_POSITION = anp_pkg::MAX_POSITION_DEF,
    parameter int QUEUE_DEPTH  = anp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_last_char,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [anp_pkg::VALUE_W-1:0]  o_number_value,
    output logic                         o_overflow_flag,
    output logic [anp_pkg::STOP_W-1:0]   o_stop_position,
    output logic                         o_suffix_used
);
    import anp_pkg::*;

    localparam int POS_W = $clog2(MAX_POSITION + 1);
    localparam int QW    = $bits(t_ch_info) + POS_W;

    logic             queue_ready;
    logic             push;
    t_ch_info         front_info;
    logic [POS_W-1:0] front_pos;
    logic             head_valid;
    logic [QW-1:0]    head_data;
    logic             back_ready;
    t_ch_info         back_info;
    logic [POS_W-1:0] back_pos;

    anp_front #(
        .MAX_POSITION (MAX_POSITION),
        .POS_W        (POS_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .i_queue_ready (queue_ready),
        .o_push        (push),
        .o_info        (front_info),
        .o_pos         (front_pos)
    );

    anp_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_info, front_pos}),
        .o_ready (queue_ready),
        .o_valid (head_valid),
        .o_data  (head_data),
        .i_pop   (head_valid && back_ready)
    );

    assign back_info = t_ch_info'(head_data[QW-1:POS_W]);
    assign back_pos  = head_data[POS_W-1:0];

    anp_back #(
        .MAX_POSITION (MAX_POSITION),
        .POS_W        (POS_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (head_valid),
        .o_ready         (back_ready),
        .i_info          (back_info),
        .i_pos           (back_pos),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_number_value  (o_number_value),
        .o_overflow_flag (o_overflow_flag),
        .o_stop_position (o_stop_position),
        .o_suffix_used   (o_suffix_used)
    );

endmodule

// ===== rtl/anp_checker.sv =====
// ----------------------------------------------------------------------------
// anp_checker
// Port-level checks on the parser top, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_number_value,
    input logic [7:0]  o_stop_position,
    input logic        o_suffix_used
);

    // stalled result beat stays
    `ANP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `ANP_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_number_value))
    // a scaled value has its low bits clear and stops past the suffix
    `ANP_ASSERT(a_sfx_low, i_clk, i_rst_n, o_valid && o_suffix_used |-> ~|o_number_value[9:0])
    `ANP_ASSERT(a_sfx_stop, i_clk, i_rst_n, o_valid && o_suffix_used |-> o_stop_position != 8'd0)
    `ANP_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind ascii_number_parser_top anp_checker u_anp_checker (.*);

// ===== dv/ascii_number_parser_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_number_parser_top_test
// Self-checking bench for the character-stream number parser. Strings are fed
// one beat per character; a tracker mirrors the parse state, builds the
// expected number for each string and compares every result beat field by
// field. Runs a directed set in both suffix modes, then random phases with
// mixed idling, a long result-side hold-off and a mid-phase drain.
// ----------------------------------------------------------------------------
module ascii_number_parser_top_test;
    import anp_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_BEATS   = 1080;
    localparam int RANDOM_PHASES  = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POS_LIMIT      = 255;
    localparam int NOT_DIGIT      = 99;

    localparam logic [31:0] SIGN_MIN   = 32'h8000_0000;
    localparam logic [31:0] KILO_SCALE = 32'h0000_0400;
    localparam logic [31:0] MEGA_SCALE = 32'h0010_0000;
    localparam logic [31:0] PAGE_SCALE = 32'd4096;

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_IDLE
    } t_scan_state;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN,
        BASE_OCT
    } t_radix;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic [STOP_W-1:0]  stop;
        logic               sfx;
    } t_number_beat;

    class t_num_scoreboard;
        logic         sfx_mode;
        t_scan_state  state;
        logic         negate;
        t_radix       radix;
        logic [31:0]  acc;
        logic         acc_ovf;
        int           pos;
        t_number_beat pending_numbers[$];
        int           n_errors;
        int           n_checked;
        int           n_scaled;
        int           n_flagged;
        int           n_saturated;

        function new();
            sfx_mode    = 1'b0;
            n_errors    = 0;
            n_checked   = 0;
            n_scaled    = 0;
            n_flagged   = 0;
            n_saturated = 0;
            clear();
        endfunction

        function void clear();
            state   = SCAN_BLANK;
            negate  = 1'b0;
            radix   = BASE_DEC;
            acc     = '0;
            acc_ovf = 1'b0;
            pos     = 0;
        endfunction

        function int sat(int p);
            return (p > POS_LIMIT) ? POS_LIMIT : p;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == " ") || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
            return NOT_DIGIT;
        endfunction

        function int base_of(t_radix r);
            case (r)
                BASE_HEX: return 16;
                BASE_BIN: return 2;
                BASE_OCT: return 8;
                default:  return 10;
            endcase
        endfunction

        function void push_number(int stop, bit has_stop, logic [7:0] c);
            t_number_beat r;
            logic [31:0]  v;
            v     = acc;
            r.ovf = acc_ovf;
            r.sfx = 1'b0;
            if (negate) begin
                if (v == SIGN_MIN) r.ovf = 1'b1;
                v = -v;
            end
            if (has_stop && sfx_mode) begin
                if (c == "k" || c == "K") begin
                    v = v * KILO_SCALE;
                    r.sfx = 1'b1;
                end else if (c == "m" || c == "M") begin
                    v = v * MEGA_SCALE;
                    r.sfx = 1'b1;
                end else if (c == "p" || c == "P") begin
                    v = v * PAGE_SCALE;
                    r.sfx = 1'b1;
                end
                if (r.sfx) stop = sat(stop + 1);
            end
            r.value = v;
            r.stop  = (stop > 255) ? 8'd255 : 8'(stop);
            pending_numbers.push_back(r);
        endfunction

        function void note_char(logic [7:0] c, logic last);
            int          d;
            int          base;
            bit          to_digit;
            bit          emitted;
            logic [63:0] prod;
            logic [32:0] sum;
            to_digit = 1'b0;
            emitted  = 1'b0;
            case (state)
                SCAN_BLANK, SCAN_SIGN: begin
                    if (state == SCAN_BLANK && is_blank(c)) begin
                        // leading whitespace
                    end else if (c == "-") begin
                        negate = ~negate;
                        state  = SCAN_SIGN;
                    end else if (c == "0") begin
                        state = SCAN_ZERO;
                    end else begin
                        radix    = BASE_DEC;
                        state    = SCAN_DIGITS;
                        to_digit = 1'b1;
                    end
                end
                SCAN_ZERO: begin
                    state = SCAN_DIGITS;
                    if (c == "x" || c == "X") begin
                        radix = BASE_HEX;
                    end else if (c == "b" || c == "B") begin
                        radix = BASE_BIN;
                    end else begin
                        radix    = BASE_OCT;
                        to_digit = 1'b1;
                    end
                end
                SCAN_DIGITS: to_digit = 1'b1;
                default: ;
            endcase
            if (to_digit) begin
                base = base_of(radix);
                d    = digit_value(c);
                if (d < base) begin
                    prod = 64'(acc) * 64'(base);
                    if (prod[63:32] != '0) acc_ovf = 1'b1;
                    sum = {1'b0, prod[31:0]} + 33'(d);
                    if (sum[32]) acc_ovf = 1'b1;
                    acc = sum[31:0];
                end else begin
                    push_number(pos, 1'b1, c);
                    emitted = 1'b1;
                end
            end
            if (!emitted && last && state != SCAN_IDLE) begin
                push_number(sat(pos + 1), 1'b0, 8'h00);
                emitted = 1'b1;
            end
            if (last) begin
                clear();
            end else begin
                if (emitted) state = SCAN_IDLE;
                pos = sat(pos + 1);
            end
        endfunction

        task report(string what);
            n_errors++;
            $display("MISMATCH %0t: %s", $realtime, what);
        endtask

        task check_result(t_number_beat got);
            t_number_beat want;
            if (pending_numbers.size() == 0) begin
                report($sformatf("unexpected result value=%h stop=%0d", got.value, got.stop));
                return;
            end
            want = pending_numbers.pop_front();
            n_checked++;
            if (want.sfx) n_scaled++;
            if (want.ovf) n_flagged++;
            if (want.stop == 8'd255) n_saturated++;
            if (got.value != want.value)
                report($sformatf("value got %h want %h", got.value, want.value));
            if (got.ovf != want.ovf)
                report($sformatf("overflow got %0b want %0b", got.ovf, want.ovf));
            if (got.stop != want.stop)
                report($sformatf("stop got %0d want %0d", got.stop, want.stop));
            if (got.sfx != want.sfx)
                report($sformatf("suffix got %0b want %0b", got.sfx, want.sfx));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_char_code;
    logic               i_last_char;
    logic               o_valid;
    logic               i_ready;
    logic [VALUE_W-1:0] o_number_value;
    logic               o_overflow_flag;
    logic [STOP_W-1:0]  o_stop_position;
    logic               o_suffix_used;

    t_num_scoreboard num_chk = new();

    logic [7:0] text_q[$];
    bit         tx_idle;
    bit         rx_idle;
    int         rx_hold_len;
    int         beats_sent;
    int         strings_sent;
    int         stall_cycles;

    ascii_number_parser_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_number_value  (o_number_value),
        .o_overflow_flag (o_overflow_flag),
        .o_stop_position (o_stop_position),
        .o_suffix_used   (o_suffix_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) num_chk.note_char(i_char_code, i_last_char);
            if (o_valid && i_ready)
                num_chk.check_result(t_number_beat'({o_number_value, o_overflow_flag,
                                                     o_stop_position, o_suffix_used}));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random gaps per beat, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 19) : 0;
            if (rx_hold_len > 0) begin
                gap = rx_hold_len;
                rx_hold_len = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        push_text(s);
        send_text();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (num_chk.pending_numbers.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain_and_settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_suffix_mode(input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        num_chk.sfx_mode = mode;
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'(" ") : 8'(r);
    endfunction

    function automatic logic [7:0] suffix_char();
        string s;
        s = "kKmMpP";
        return s[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] digit_char(t_radix r);
        int v;
        case (r)
            BASE_HEX: begin
                v = $urandom_range(0, 15);
                if (v < 10) return 8'("0" + v);
                return ($urandom_range(0, 1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
            end
            BASE_BIN: return 8'("0" + $urandom_range(0, 1));
            BASE_OCT: return 8'("0" + $urandom_range(0, 7));
            default:  return 8'("0" + $urandom_range(0, 9));
        endcase
    endfunction

    task automatic make_random_string();
        int     kind;
        int     n;
        t_radix r;
        text_q.delete();
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            if ($urandom_range(0, 149) == 0) n = $urandom_range(250, 300);
            repeat (n) text_q.push_back(blank_char());
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n) text_q.push_back("-");
            r = t_radix'($urandom_range(0, 3));
            case (r)
                BASE_HEX: push_text(($urandom_range(0, 1) != 0) ? "0x" : "0X");
                BASE_BIN: push_text(($urandom_range(0, 1) != 0) ? "0b" : "0B");
                BASE_OCT: text_q.push_back("0");
                default: ;
            endcase
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 8);
            repeat (n) text_q.push_back(digit_char(r));
            case ($urandom_range(0, 5))
                0, 1: text_q.push_back(suffix_char());
                2: text_q.push_back(blank_char());
                3: text_q.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
            n = $urandom_range(0, 3);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 17) begin
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 7))
                0: push_text("-2147483648");
                1: push_text("4294967295");
                2: push_text("4294967296");
                3: push_text("-0x80000000");
                4: push_text("0xffffFFFF");
                5: push_text("0x100000000");
                6: push_text("0b11111111111111111111111111111111");
                default: push_text("-037777777777");
            endcase
            if ($urandom_range(0, 1) != 0) text_q.push_back(suffix_char());
        end
        if (text_q.size() == 0) text_q.push_back("0");
    endtask

    task automatic run_directed();
        send_string("- 7");
        send_string("0xg");
        send_string("0B2");
        text_q = '{8'h00};
        send_text();
        text_q = '{"9", 8'hFF, 8'h80};
        send_text();
        send_string(" 017");
        send_string("1kx");
        send_string("--5M");
        send_string("Z");
    endtask

    initial begin : stimulus
        int target;
        bit paused;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= '0;
        i_last_char <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        rx_hold_len = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_and_settle();
        write_suffix_mode(1'b1);
        run_directed();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_and_settle();
            write_suffix_mode(ph == 1 || ph == 2 || ph == 4);
            tx_idle = (ph != 1 && ph != 3);
            rx_idle = (ph != 1 && ph != 2);
            if (ph == 1) rx_hold_len = HOLD_CYCLES;
            if (ph == 0) begin
                text_q.delete();
                repeat (260) text_q.push_back(" ");
                push_text("-42k");
                send_text();
            end
            target = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
            paused = 1'b0;
            while (beats_sent < target) begin
                make_random_string();
                send_text();
                if (ph == 3 && !paused && beats_sent > target - RANDOM_BEATS / 12) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        drain_and_settle();

        $display("Sent %0d characters in %0d strings; checked %0d numbers", beats_sent,
                 strings_sent, num_chk.n_checked);
        $display("Suffix-scaled %0d, overflowed %0d, saturated stop %0d, mismatches %0d",
                 num_chk.n_scaled, num_chk.n_flagged, num_chk.n_saturated, num_chk.n_errors);
        if (num_chk.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
